>>> src/piu_pkg.sv
package piu_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    // wide accumulator for exact dot and cross sums and for the point adds
    localparam int SW  = (2 * COORD_WIDTH + 4 > 65) ? 2 * COORD_WIDTH + 4 : 65;
    localparam int VW  = COORD_WIDTH + 1;
    localparam int PW  = 2 * VW;
    localparam int NW  = PW;
    localparam int DW  = COORD_WIDTH + 1;
    localparam int OW  = 63;
    localparam int QAW = 2;
    localparam int QD  = 2 ** QAW;
    localparam int CFG_IW = 3;

    typedef logic signed [COORD_WIDTH-1:0] t_crd;
    typedef t_crd [2:0] t_vec;
    typedef logic signed [SW-1:0] t_wide;

    localparam logic [2:0] CMD_DIST  = 3'd0;
    localparam logic [2:0] CMD_SEG   = 3'd1;
    localparam logic [2:0] CMD_LINE  = 3'd2;
    localparam logic [2:0] CMD_RAY   = 3'd3;
    localparam logic [2:0] CMD_PLANE = 3'd4;

    localparam logic [CFG_IW-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IW-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IW-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IW-1:0] REG_NORMAL_X = 3'd3;
    localparam logic [CFG_IW-1:0] REG_NORMAL_Y = 3'd4;
    localparam logic [CFG_IW-1:0] REG_NORMAL_Z = 3'd5;

    typedef enum logic [2:0] {
        CLS_DIST,
        CLS_SEG,
        CLS_LINE,
        CLS_RAY,
        CLS_PLANE,
        CLS_NONE
    } t_cls;

    typedef struct packed {
        logic [2:0] command;
        t_crd       point_a_x;
        t_crd       point_a_y;
        t_crd       point_a_z;
        t_crd       vector_b_x;
        t_crd       vector_b_y;
        t_crd       vector_b_z;
    } t_in;

    typedef struct packed {
        logic hit;
        t_crd signed_distance;
        t_crd hit_x;
        t_crd hit_y;
        t_crd hit_z;
        t_crd line_dir_x;
        t_crd line_dir_y;
        t_crd line_dir_z;
    } t_out;

    typedef struct packed {
        t_cls cls;
        t_vec a;
        t_vec b;
    } t_job;

    localparam t_wide RHALF = t_wide'(1) << (FRAC_BITS - 1);

    function automatic t_crd sat_crd(input t_wide x);
        t_wide hi;
        t_wide lo;
        t_crd  r;
        hi = t_wide'({(COORD_WIDTH-1){1'b1}});
        lo = -hi - t_wide'(1);
        if (x > hi) begin
            r = hi[COORD_WIDTH-1:0];
        end else if (x < lo) begin
            r = lo[COORD_WIDTH-1:0];
        end else begin
            r = x[COORD_WIDTH-1:0];
        end
        return r;
    endfunction

    // round half up to the fraction point, then saturate
    function automatic t_crd rnd(input t_wide x);
        t_wide t;
        t = (x + RHALF) >>> FRAC_BITS;
        return sat_crd(t);
    endfunction

endpackage

>>> src/piu_front.sv
module piu_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  piu_pkg::t_in  i_in_item,
    output logic          o_job_valid,
    input  logic          i_job_ready,
    output piu_pkg::t_job o_job
);
    import piu_pkg::*;

    t_job           r_mem [QD];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QAW:0]   r_cnt;
    t_job           n_job;
    logic           push;
    logic           pop;

    assign o_in_ready  = r_cnt != (QAW+1)'(QD);
    assign o_job_valid = r_cnt != '0;
    assign o_job       = r_mem[r_rp];
    assign push        = i_in_valid && o_in_ready;
    assign pop         = o_job_valid && i_job_ready;

    always_comb begin
        case (i_in_item.command)
            CMD_DIST:  n_job.cls = CLS_DIST;
            CMD_SEG:   n_job.cls = CLS_SEG;
            CMD_LINE:  n_job.cls = CLS_LINE;
            CMD_RAY:   n_job.cls = CLS_RAY;
            CMD_PLANE: n_job.cls = CLS_PLANE;
            default:   n_job.cls = CLS_NONE;
        endcase
        n_job.a[0] = i_in_item.point_a_x;
        n_job.a[1] = i_in_item.point_a_y;
        n_job.a[2] = i_in_item.point_a_z;
        n_job.b[0] = i_in_item.vector_b_x;
        n_job.b[1] = i_in_item.vector_b_y;
        n_job.b[2] = i_in_item.vector_b_z;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= n_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QAW+1)'(push) - (QAW+1)'(pop);
        end
    end

endmodule

>>> src/piu_div.sv
module piu_div (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [piu_pkg::NW-1:0] i_num,
    input  logic [piu_pkg::DW-1:0] i_den,
    output logic [piu_pkg::NW-1:0] o_quo
);
    import piu_pkg::*;

    // one quotient bit per stage, numerator msb first
    logic [DW-1:0] r_rem [NW];
    logic [NW-1:0] r_num [NW];
    logic [NW-1:0] r_quo [NW];
    logic [DW-1:0] r_den [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [DW-1:0] p_rem;
        logic [NW-1:0] p_num;
        logic [NW-1:0] p_quo;
        logic [DW-1:0] p_den;
        logic [DW:0]   t;
        logic          qb;
        logic [DW-1:0] n_rem;

        if (k == 0) begin : g_first
            assign p_rem = '0;
            assign p_num = i_num;
            assign p_quo = '0;
            assign p_den = i_den;
        end else begin : g_next
            assign p_rem = r_rem[k-1];
            assign p_num = r_num[k-1];
            assign p_quo = r_quo[k-1];
            assign p_den = r_den[k-1];
        end

        always_comb begin
            t = {p_rem, p_num[NW-1]};
            if (t >= {1'b0, p_den}) begin
                qb    = 1'b1;
                n_rem = DW'(t - {1'b0, p_den});
            end else begin
                qb    = 1'b0;
                n_rem = t[DW-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_num[k] <= {p_num[NW-2:0], 1'b0};
                r_quo[k] <= {p_quo[NW-2:0], qb};
                r_den[k] <= p_den;
            end
        end
    end

    assign o_quo = r_quo[NW-1];

endmodule

>>> src/piu_back.sv
module piu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    output logic          o_job_ready,
    input  piu_pkg::t_job i_job,
    input  piu_pkg::t_vec i_org,
    input  piu_pkg::t_vec i_nrm,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output piu_pkg::t_out o_out
);
    import piu_pkg::*;

    localparam int NXT [3] = '{1, 2, 0};
    localparam int PRV [3] = '{2, 0, 1};
    localparam t_wide OMAX = t_wide'({(OW-1){1'b1}});
    localparam t_wide OMIN = -OMAX - t_wide'(1);

    typedef struct packed {
        logic vld;
        t_cls cls;
        logic same;
        logic opp;
        t_vec a;
        t_vec b;
    } t_ctx;

    typedef struct packed {
        logic       vld;
        logic       hit;
        t_cls       cls;
        t_crd       sdist;
        t_vec       a;
        t_vec       c;
        logic [2:0] neg;
    } t_side;

    logic en;
    assign en          = !o_out_valid || i_out_ready;
    assign o_job_ready = en;

    t_crd a0 [3];
    t_crd b0 [3];
    t_crd org [3];
    t_crd nrm [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            a0[i]  = $signed(i_job.a[i]);
            b0[i]  = $signed(i_job.b[i]);
            org[i] = $signed(i_org[i]);
            nrm[i] = $signed(i_nrm[i]);
        end
    end

    // stage 1: differences, first cross products, normal compares
    t_ctx                          r1_ctx, n1_ctx;
    logic signed [VW-1:0]          r1_da [3], n1_da [3];
    logic signed [VW-1:0]          r1_db [3], n1_db [3];
    logic signed [2*COORD_WIDTH-1:0] r1_pcp [3], n1_pcp [3];
    logic signed [2*COORD_WIDTH-1:0] r1_pcm [3], n1_pcm [3];

    always_comb begin
        n1_ctx.vld  = i_job_valid;
        n1_ctx.cls  = i_job.cls;
        n1_ctx.a    = i_job.a;
        n1_ctx.b    = i_job.b;
        n1_ctx.same = 1'b1;
        n1_ctx.opp  = 1'b1;
        for (int i = 0; i < 3; i++) begin
            n1_da[i]  = VW'(a0[i]) - VW'(org[i]);
            n1_db[i]  = VW'(b0[i]) - VW'(org[i]);
            n1_pcp[i] = nrm[NXT[i]] * b0[PRV[i]];
            n1_pcm[i] = nrm[PRV[i]] * b0[NXT[i]];
            if (nrm[i] != b0[i]) begin
                n1_ctx.same = 1'b0;
            end
            if (-VW'(nrm[i]) != VW'(b0[i])) begin
                n1_ctx.opp = 1'b0;
            end
        end
    end

    // stage 2: dot products, cross n x b rounded
    t_ctx                     r2_ctx;
    logic signed [VW+COORD_WIDTH-1:0] r2_pda [3], n2_pda [3];
    logic signed [VW+COORD_WIDTH-1:0] r2_pdb [3], n2_pdb [3];
    logic signed [VW+COORD_WIDTH-1:0] r2_pbn [3], n2_pbn [3];
    t_crd                     r2_c [3], n2_c [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n2_pda[i] = r1_da[i] * nrm[i];
            n2_pdb[i] = r1_db[i] * nrm[i];
            n2_pbn[i] = VW'($signed(r1_ctx.b[i])) * nrm[i];
            n2_c[i]   = rnd(t_wide'(r1_pcp[i]) - t_wide'(r1_pcm[i]));
        end
    end

    // stage 3: distances, products for (n x b) x b
    t_ctx r3_ctx;
    t_crd r3_c [3];
    t_crd r3_d1, r3_d2, r3_dnl, n3_d1, n3_d2, n3_dnl;
    logic signed [2*COORD_WIDTH-1:0] r3_pep [3], n3_pep [3];
    logic signed [2*COORD_WIDTH-1:0] r3_pem [3], n3_pem [3];

    always_comb begin
        n3_d1  = rnd(t_wide'(r2_pda[0]) + t_wide'(r2_pda[1]) + t_wide'(r2_pda[2]));
        n3_d2  = rnd(t_wide'(r2_pdb[0]) + t_wide'(r2_pdb[1]) + t_wide'(r2_pdb[2]));
        n3_dnl = rnd(t_wide'(r2_pbn[0]) + t_wide'(r2_pbn[1]) + t_wide'(r2_pbn[2]));
        for (int i = 0; i < 3; i++) begin
            n3_pep[i] = r2_c[NXT[i]] * $signed(r2_ctx.b[PRV[i]]);
            n3_pem[i] = r2_c[PRV[i]] * $signed(r2_ctx.b[NXT[i]]);
        end
    end

    // stage 4: inner line direction e rounded
    t_ctx r4_ctx;
    t_crd r4_c [3];
    t_crd r4_d1, r4_d2, r4_dnl;
    t_crd r4_e [3], n4_e [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n4_e[i] = rnd(t_wide'(r3_pep[i]) - t_wide'(r3_pem[i]));
        end
    end

    // stage 5: e . n products
    t_ctx r5_ctx;
    t_crd r5_c [3];
    t_crd r5_e [3];
    t_crd r5_d1, r5_d2, r5_dnl;
    logic signed [2*COORD_WIDTH-1:0] r5_pen [3], n5_pen [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n5_pen[i] = r4_e[i] * nrm[i];
        end
    end

    // stage 6: e . n rounded
    t_ctx r6_ctx;
    t_crd r6_c [3];
    t_crd r6_e [3];
    t_crd r6_d1, r6_d2, r6_dnl, r6_dnp, n6_dnp;

    assign n6_dnp = rnd(t_wide'(r5_pen[0]) + t_wide'(r5_pen[1]) + t_wide'(r5_pen[2]));

    // stage 7: hit decision and divider operand select
    t_side                r7_side, n7_side;
    logic signed [VW-1:0] r7_v [3], n7_v [3];
    logic signed [VW-1:0] r7_m, n7_m;
    logic [DW-1:0]        r7_den, n7_den;
    logic                 r7_dneg, n7_dneg;
    logic signed [VW-1:0] m1, m2, nd;
    logic [DW-1:0]        dnl_mag, dnp_mag;

    always_comb begin
        m1      = (r6_d1 < 0) ? -VW'(r6_d1) : VW'(r6_d1);
        m2      = (r6_d2 < 0) ? -VW'(r6_d2) : VW'(r6_d2);
        nd      = -VW'(r6_d1);
        dnl_mag = (r6_dnl < 0) ? DW'(-VW'(r6_dnl)) : DW'(VW'(r6_dnl));
        dnp_mag = (r6_dnp < 0) ? DW'(-VW'(r6_dnp)) : DW'(VW'(r6_dnp));

        n7_side.vld   = r6_ctx.vld;
        n7_side.cls   = r6_ctx.cls;
        n7_side.sdist = r6_d1;
        n7_side.a     = r6_ctx.a;
        n7_side.neg   = '0;
        for (int i = 0; i < 3; i++) begin
            n7_side.c[i] = r6_c[i];
            n7_v[i]      = '0;
        end
        n7_side.hit = 1'b0;
        n7_m        = '0;
        n7_den      = '0;
        n7_dneg     = 1'b0;

        case (r6_ctx.cls)
            CLS_DIST: begin
                n7_side.hit = 1'b1;
            end
            CLS_SEG: begin
                n7_side.hit = (r6_d1 > 0 && r6_d2 < 0) || (r6_d1 < 0 && r6_d2 > 0);
                n7_m        = m1;
                n7_den      = DW'(m1) + DW'(m2);
                for (int i = 0; i < 3; i++) begin
                    n7_v[i] = VW'($signed(r6_ctx.b[i])) - VW'($signed(r6_ctx.a[i]));
                end
            end
            CLS_LINE, CLS_RAY: begin
                n7_side.hit = r6_dnl != 0;
                // a ray pointing away from the plane misses
                if (r6_ctx.cls == CLS_RAY &&
                    ((r6_dnl > 0 && r6_d1 > 0) || (r6_dnl < 0 && r6_d1 < 0))) begin
                    n7_side.hit = 1'b0;
                end
                n7_m    = nd;
                n7_den  = dnl_mag;
                n7_dneg = r6_dnl < 0;
                for (int i = 0; i < 3; i++) begin
                    n7_v[i] = VW'($signed(r6_ctx.b[i]));
                end
            end
            CLS_PLANE: begin
                n7_side.hit = !r6_ctx.same && !r6_ctx.opp && r6_dnp != 0;
                n7_m        = nd;
                n7_den      = dnp_mag;
                n7_dneg     = r6_dnp < 0;
                for (int i = 0; i < 3; i++) begin
                    n7_v[i] = VW'(r6_e[i]);
                end
            end
            default: begin
                n7_side.hit = 1'b0;
            end
        endcase
    end

    // stage 8: numerator products
    t_side                r8_side;
    logic signed [PW-1:0] r8_p [3], n8_p [3];
    logic [DW-1:0]        r8_den;
    logic                 r8_dneg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n8_p[i] = r7_v[i] * r7_m;
        end
    end

    // stage 9: magnitudes and quotient signs
    t_side         r9_side, n9_side;
    logic [NW-1:0] r9_mag [3], n9_mag [3];
    logic [DW-1:0] r9_den;

    always_comb begin
        n9_side = r8_side;
        for (int i = 0; i < 3; i++) begin
            n9_side.neg[i] = r8_p[i][PW-1] ^ r8_dneg;
            n9_mag[i]      = r8_p[i][PW-1] ? NW'(-r8_p[i]) : NW'(r8_p[i]);
        end
    end

    logic [NW-1:0] quo [3];

    for (genvar g = 0; g < 3; g++) begin : g_div
        piu_div u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r9_mag[g]),
            .i_den (r9_den),
            .o_quo (quo[g])
        );
    end

    t_side r_sdl [NW];

    // quotient sign and clamp to the offset range
    t_side r_q_side;
    t_wide r_q_off [3], n_q_off [3];
    t_wide qm [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            qm[i] = t_wide'(quo[i]);
            if (r_sdl[NW-1].neg[i]) begin
                n_q_off[i] = (qm[i] > OMAX + t_wide'(1)) ? OMIN : -qm[i];
            end else begin
                n_q_off[i] = (qm[i] > OMAX) ? OMAX : qm[i];
            end
        end
    end

    // output register
    logic r_out_vld;
    t_out r_out, n_out;
    t_crd pt [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pt[i] = sat_crd(t_wide'($signed(r_q_side.a[i])) + r_q_off[i]);
        end
        n_out                 = '0;
        n_out.hit             = r_q_side.hit;
        n_out.signed_distance = r_q_side.sdist;
        if (r_q_side.hit && r_q_side.cls != CLS_DIST) begin
            n_out.hit_x = pt[0];
            n_out.hit_y = pt[1];
            n_out.hit_z = pt[2];
        end
        if (r_q_side.hit && r_q_side.cls == CLS_PLANE) begin
            n_out.line_dir_x = r_q_side.c[0];
            n_out.line_dir_y = r_q_side.c[1];
            n_out.line_dir_z = r_q_side.c[2];
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctx    <= '0;
            r2_ctx    <= '0;
            r3_ctx    <= '0;
            r4_ctx    <= '0;
            r5_ctx    <= '0;
            r6_ctx    <= '0;
            r7_side   <= '0;
            r8_side   <= '0;
            r9_side   <= '0;
            r_q_side  <= '0;
            r_out_vld <= 1'b0;
            for (int k = 0; k < NW; k++) begin
                r_sdl[k] <= '0;
            end
        end else if (en) begin
            r1_ctx    <= n1_ctx;
            r2_ctx    <= r1_ctx;
            r3_ctx    <= r2_ctx;
            r4_ctx    <= r3_ctx;
            r5_ctx    <= r4_ctx;
            r6_ctx    <= r5_ctx;
            r7_side   <= n7_side;
            r8_side   <= r7_side;
            r9_side   <= n9_side;
            r_sdl[0]  <= r9_side;
            for (int k = 1; k < NW; k++) begin
                r_sdl[k] <= r_sdl[k-1];
            end
            r_q_side  <= r_sdl[NW-1];
            r_out_vld <= r_q_side.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r1_da[i]   <= n1_da[i];
                r1_db[i]   <= n1_db[i];
                r1_pcp[i]  <= n1_pcp[i];
                r1_pcm[i]  <= n1_pcm[i];
                r2_pda[i]  <= n2_pda[i];
                r2_pdb[i]  <= n2_pdb[i];
                r2_pbn[i]  <= n2_pbn[i];
                r2_c[i]    <= n2_c[i];
                r3_c[i]    <= r2_c[i];
                r3_pep[i]  <= n3_pep[i];
                r3_pem[i]  <= n3_pem[i];
                r4_c[i]    <= r3_c[i];
                r4_e[i]    <= n4_e[i];
                r5_c[i]    <= r4_c[i];
                r5_e[i]    <= r4_e[i];
                r5_pen[i]  <= n5_pen[i];
                r6_c[i]    <= r5_c[i];
                r6_e[i]    <= r5_e[i];
                r7_v[i]    <= n7_v[i];
                r8_p[i]    <= n8_p[i];
                r9_mag[i]  <= n9_mag[i];
                r_q_off[i] <= n_q_off[i];
            end
            r3_d1   <= n3_d1;
            r3_d2   <= n3_d2;
            r3_dnl  <= n3_dnl;
            r4_d1   <= r3_d1;
            r4_d2   <= r3_d2;
            r4_dnl  <= r3_dnl;
            r5_d1   <= r4_d1;
            r5_d2   <= r4_d2;
            r5_dnl  <= r4_dnl;
            r6_d1   <= r5_d1;
            r6_d2   <= r5_d2;
            r6_dnl  <= r5_dnl;
            r6_dnp  <= n6_dnp;
            r7_m    <= n7_m;
            r7_den  <= n7_den;
            r7_dneg <= n7_dneg;
            r8_den  <= r7_den;
            r8_dneg <= r7_dneg;
            r9_den  <= r8_den;
            r_out   <= n_out;
        end
    end

endmodule

>>> src/plane_intersection_unit.sv
// Plane intersection unit: answers distance, segment, line, ray and plane-plane
// queries against one configured plane in signed Q16.16. It takes one item per
// clock cycle while its input queue has room and holds up to four items in that
// queue. The fully pipelined divider, which resolves one quotient bit per stage,
// sits behind nine stages of products, rounding and operand selection and ahead
// of a sign stage and the output register. While a result waits at the output
// the whole arithmetic pipeline holds, and the input keeps taking items until
// the queue is full. Configuration writes take effect at once and are meant to
// be made while no item is in flight.
module plane_intersection_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  piu_pkg::t_in                   i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output piu_pkg::t_out                  o_out_item,
    input  logic                           i_cfg_we,
    input  logic [piu_pkg::CFG_IW-1:0]     i_cfg_index,
    input  logic [piu_pkg::COORD_WIDTH-1:0] i_cfg_data
);
    import piu_pkg::*;

    t_vec r_org;
    t_vec r_nrm;
    logic job_valid;
    logic job_ready;
    t_job job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org <= '0;
            r_nrm <= {t_crd'(0), t_crd'(1) << FRAC_BITS, t_crd'(0)};
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ORIGIN_X: r_org[0] <= i_cfg_data;
                REG_ORIGIN_Y: r_org[1] <= i_cfg_data;
                REG_ORIGIN_Z: r_org[2] <= i_cfg_data;
                REG_NORMAL_X: r_nrm[0] <= i_cfg_data;
                REG_NORMAL_Y: r_nrm[1] <= i_cfg_data;
                REG_NORMAL_Z: r_nrm[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    piu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_job_valid (job_valid),
        .i_job_ready (job_ready),
        .o_job       (job)
    );

    piu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .o_job_ready (job_ready),
        .i_job       (job),
        .i_org       (r_org),
        .i_nrm       (r_nrm),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out_item)
    );

endmodule

>>> src/piu_checker.sv
module piu_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input piu_pkg::t_out o_out_item
);
    import piu_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_item))
        else $error("output item changed while stalled");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.hit |->
            o_out_item.hit_x == 0 && o_out_item.hit_y == 0 && o_out_item.hit_z == 0 &&
            o_out_item.line_dir_x == 0 && o_out_item.line_dir_y == 0 &&
            o_out_item.line_dir_z == 0)
        else $error("miss carries a point or direction");

    a_dir_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.line_dir_x != 0 || o_out_item.line_dir_y != 0 ||
            o_out_item.line_dir_z != 0) |-> o_out_item.hit)
        else $error("line direction without a hit");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind plane_intersection_unit piu_checker u_piu_checker (.*);
